[rtl/cbor_ihd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbor_ihd_pkg
// Shared types and constants for the CBOR item head decoder.
// ----------------------------------------------------------------------------
package cbor_ihd_pkg;

    typedef enum logic [1:0] {
        PH_HEAD    = 2'd0,
        PH_ARG     = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_ERROR   = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        EV_UINT      = 4'd0,
        EV_NEGINT    = 4'd1,
        EV_BYTES     = 4'd2,
        EV_TEXT      = 4'd3,
        EV_PAYLOAD   = 4'd4,
        EV_ARRAY     = 4'd5,
        EV_MAP       = 4'd6,
        EV_TAG       = 4'd7,
        EV_SIMPLE    = 4'd8,
        EV_FALSE     = 4'd9,
        EV_TRUE      = 4'd10,
        EV_NULL      = 4'd11,
        EV_UNDEFINED = 4'd12,
        EV_EXTSPEC   = 4'd13,
        EV_ERROR     = 4'd14
    } event_kind_t;

    localparam logic ERR_BAD_INFO   = 1'b0;
    localparam logic ERR_LONG_LENGTH = 1'b1;

    localparam logic [2:0] MT_UINT   = 3'd0;
    localparam logic [2:0] MT_NEGINT = 3'd1;
    localparam logic [2:0] MT_BYTES  = 3'd2;
    localparam logic [2:0] MT_TEXT   = 3'd3;
    localparam logic [2:0] MT_ARRAY  = 3'd4;
    localparam logic [2:0] MT_MAP    = 3'd5;
    localparam logic [2:0] MT_TAG    = 3'd6;

    localparam logic [4:0] AI_IMM_MAX  = 5'h17;
    localparam logic [4:0] AI_ARG8_MAX = 5'h1B;
    localparam logic [4:0] AI_FALSE    = 5'h14;

    typedef struct packed {
        phase_t      phase;
        logic [2:0]  major;
        logic [3:0]  bytes_left;
        logic [3:0]  arg_width;
        logic [63:0] acc;
    } head_state_t;

    typedef struct packed {
        event_kind_t kind;
        logic [63:0] argument;
        logic        wide;
        logic [3:0]  size;
        logic [7:0]  pbyte;
        logic        last;
        logic        err;
    } head_event_t;

endpackage

[rtl/cbor_item_head_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbor_item_head_decoder
// Streaming CBOR item head decoder: one encoded byte in, at most one event out.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries the encoded stream, one byte per transaction in tdata[7:0].
//   m_axis carries decoded events. tuser holds the event kind and error code,
//   tdata the argument and its attributes, tlast marks the final payload byte
//   of a byte or text string.
//   Each byte passes an input register and then the decode logic, which
//   updates the head state and loads the result register that drives
//   m_axis_tvalid. Bytes that complete no event (argument bytes still
//   pending, or any byte after an error) leave no transaction.
//   Throughput is one byte per cycle while m_axis does not stall, bounded by
//   the update of the argument accumulator and payload counter.
//   When m_axis stalls with an event held, the byte in the input register
//   waits and s_axis_tready drops; nothing is lost.
//   Reset clears the pipeline and returns the decoder to waiting for a head
//   byte. An error event latches the decoder until the next reset.
// ----------------------------------------------------------------------------
module cbor_item_head_decoder #(
    parameter int LENGTH_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // [63:0] argument, [64] wide_integer,
                                        // [68:65] argument_size,
                                        // [76:69] payload_byte, [79:77] zero
    output logic [4:0]  m_axis_tuser,   // [3:0] event_kind, [4] error_code
    output logic        m_axis_tlast    // last_payload
);

    logic                       in_valid_reg;
    logic [7:0]                 in_byte_reg;
    cbor_ihd_pkg::head_state_t  state_reg;
    cbor_ihd_pkg::head_state_t  state_next;
    logic [LENGTH_BITS-1:0]     payload_left_reg;
    logic [LENGTH_BITS-1:0]     payload_left_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    cbor_ihd_pkg::head_event_t  out_event_reg;
    cbor_ihd_pkg::head_event_t  event_next;
    logic                       emit;
    logic                       advance;

    assign advance        = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready  = !in_valid_reg || advance;
    assign out_valid_next = (advance && emit) || (out_valid_reg && !m_axis_tready);

    cbor_ihd_decode #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_decode (
        .state             (state_reg),
        .payload_left      (payload_left_reg),
        .data_byte         (in_byte_reg),
        .state_next        (state_next),
        .payload_left_next (payload_left_next),
        .emit              (emit),
        .event_out         (event_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            state_reg.phase    <= cbor_ihd_pkg::PH_HEAD;
            state_reg.major    <= 3'd0;
            state_reg.bytes_left <= 4'd0;
            state_reg.arg_width  <= 4'd0;
            state_reg.acc      <= 64'd0;
            payload_left_reg   <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg        <= state_next;
                payload_left_reg <= payload_left_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (advance && emit)
        begin
            out_event_reg <= event_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'd0, out_event_reg.pbyte, out_event_reg.size,
                            out_event_reg.wide, out_event_reg.argument};
    assign m_axis_tuser  = {out_event_reg.err, out_event_reg.kind};
    assign m_axis_tlast  = out_event_reg.last;

    property p_error_latched;
        @(posedge clk) disable iff (!rst_n)
        state_reg.phase == cbor_ihd_pkg::PH_ERROR |=>
            state_reg.phase == cbor_ihd_pkg::PH_ERROR;
    endproperty
    a_error_latched: assert property (p_error_latched)
        else $error("decoder left the error phase without reset");

    property p_last_is_payload;
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_event_reg.last |->
            out_event_reg.kind == cbor_ihd_pkg::EV_PAYLOAD;
    endproperty
    a_last_is_payload: assert property (p_last_is_payload)
        else $error("tlast on a non-payload event");

    property p_arg_pending;
        @(posedge clk) disable iff (!rst_n)
        state_reg.phase == cbor_ihd_pkg::PH_ARG |-> state_reg.bytes_left != 4'd0;
    endproperty
    a_arg_pending: assert property (p_arg_pending)
        else $error("argument phase with no bytes left");

    property p_payload_pending;
        @(posedge clk) disable iff (!rst_n)
        state_reg.phase == cbor_ihd_pkg::PH_PAYLOAD |-> payload_left_reg != '0;
    endproperty
    a_payload_pending: assert property (p_payload_pending)
        else $error("payload phase with zero bytes left");

endmodule

[rtl/cbor_ihd_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbor_ihd_decode
// Next-state and event logic for one stream byte of the head decoder.
// ----------------------------------------------------------------------------
module cbor_ihd_decode #(
    parameter int LENGTH_BITS = 32
) (
    input  cbor_ihd_pkg::head_state_t  state,
    input  logic [LENGTH_BITS-1:0]     payload_left,
    input  logic [7:0]                 data_byte,
    output cbor_ihd_pkg::head_state_t  state_next,
    output logic [LENGTH_BITS-1:0]     payload_left_next,
    output logic                       emit,
    output cbor_ihd_pkg::head_event_t  event_out
);

    logic [4:0]              ai;
    logic [63:0]             acc_shift;
    logic                    do_finish;
    logic [2:0]              fin_major;
    logic [63:0]             fin_value;
    logic [3:0]              fin_size;
    logic [LENGTH_BITS-1:0]  payload_dec;

    assign ai          = data_byte[4:0];
    assign acc_shift   = {state.acc[55:0], data_byte};
    assign payload_dec = payload_left - LENGTH_BITS'(1);

    always_comb
    begin
        state_next          = state;
        payload_left_next   = payload_left;
        emit                = 1'b0;
        event_out           = '0;
        event_out.kind      = cbor_ihd_pkg::EV_UINT;
        do_finish           = 1'b0;
        fin_major           = state.major;
        fin_value           = acc_shift;
        fin_size            = state.arg_width;

        case (state.phase)
            cbor_ihd_pkg::PH_HEAD:
            begin
                state_next.major = data_byte[7:5];
                fin_major        = data_byte[7:5];
                if (ai <= cbor_ihd_pkg::AI_IMM_MAX)
                begin
                    do_finish = 1'b1;
                    fin_value = {59'd0, ai};
                    fin_size  = 4'd0;
                end
                else if (ai <= cbor_ihd_pkg::AI_ARG8_MAX)
                begin
                    state_next.arg_width  = 4'd1 << ai[1:0];
                    state_next.bytes_left = 4'd1 << ai[1:0];
                    state_next.acc        = '0;
                    state_next.phase      = cbor_ihd_pkg::PH_ARG;
                end
                else
                begin
                    state_next.phase   = cbor_ihd_pkg::PH_ERROR;
                    emit               = 1'b1;
                    event_out.kind     = cbor_ihd_pkg::EV_ERROR;
                    event_out.argument = {59'd0, ai};
                    event_out.err      = cbor_ihd_pkg::ERR_BAD_INFO;
                end
            end
            cbor_ihd_pkg::PH_ARG:
            begin
                state_next.acc = acc_shift;
                if (state.bytes_left != 4'd0)
                begin
                    state_next.bytes_left = state.bytes_left - 4'd1;
                end
                if (state.bytes_left <= 4'd1)
                begin
                    do_finish = 1'b1;
                end
            end
            cbor_ihd_pkg::PH_PAYLOAD:
            begin
                emit            = 1'b1;
                event_out.kind  = cbor_ihd_pkg::EV_PAYLOAD;
                event_out.pbyte = data_byte;
                if (payload_left != '0)
                begin
                    payload_left_next = payload_dec;
                end
                if (payload_left <= LENGTH_BITS'(1))
                begin
                    event_out.last   = 1'b1;
                    state_next.phase = cbor_ihd_pkg::PH_HEAD;
                end
            end
            default:
            begin
                state_next.phase = cbor_ihd_pkg::PH_ERROR;
            end
        endcase

        if (do_finish)
        begin
            emit               = 1'b1;
            state_next.phase   = cbor_ihd_pkg::PH_HEAD;
            event_out.argument = fin_value;
            event_out.size     = fin_size;
            case (fin_major)
                cbor_ihd_pkg::MT_UINT, cbor_ihd_pkg::MT_NEGINT:
                begin
                    event_out.kind = (fin_major == cbor_ihd_pkg::MT_UINT) ?
                                     cbor_ihd_pkg::EV_UINT : cbor_ihd_pkg::EV_NEGINT;
                    event_out.wide = |fin_value[63:31];
                end
                cbor_ihd_pkg::MT_BYTES, cbor_ihd_pkg::MT_TEXT,
                cbor_ihd_pkg::MT_ARRAY, cbor_ihd_pkg::MT_MAP:
                begin
                    if (fin_size == 4'd8 || (fin_value >> LENGTH_BITS) != 64'd0)
                    begin
                        state_next.phase = cbor_ihd_pkg::PH_ERROR;
                        event_out.kind   = cbor_ihd_pkg::EV_ERROR;
                        event_out.err    = cbor_ihd_pkg::ERR_LONG_LENGTH;
                    end
                    else
                    begin
                        case (fin_major)
                            cbor_ihd_pkg::MT_BYTES: event_out.kind = cbor_ihd_pkg::EV_BYTES;
                            cbor_ihd_pkg::MT_TEXT:  event_out.kind = cbor_ihd_pkg::EV_TEXT;
                            cbor_ihd_pkg::MT_ARRAY: event_out.kind = cbor_ihd_pkg::EV_ARRAY;
                            default:                event_out.kind = cbor_ihd_pkg::EV_MAP;
                        endcase
                        if (fin_major == cbor_ihd_pkg::MT_BYTES ||
                            fin_major == cbor_ihd_pkg::MT_TEXT)
                        begin
                            payload_left_next = fin_value[LENGTH_BITS-1:0];
                            if (fin_value[LENGTH_BITS-1:0] != '0)
                            begin
                                state_next.phase = cbor_ihd_pkg::PH_PAYLOAD;
                            end
                        end
                    end
                end
                cbor_ihd_pkg::MT_TAG:
                begin
                    event_out.kind = cbor_ihd_pkg::EV_TAG;
                end
                default:
                begin
                    if (fin_size != 4'd0)
                    begin
                        event_out.kind = cbor_ihd_pkg::EV_EXTSPEC;
                    end
                    else if (fin_value[4:0] < cbor_ihd_pkg::AI_FALSE)
                    begin
                        event_out.kind = cbor_ihd_pkg::EV_SIMPLE;
                    end
                    else
                    begin
                        case (fin_value[1:0])
                            2'd0:    event_out.kind = cbor_ihd_pkg::EV_FALSE;
                            2'd1:    event_out.kind = cbor_ihd_pkg::EV_TRUE;
                            2'd2:    event_out.kind = cbor_ihd_pkg::EV_NULL;
                            default: event_out.kind = cbor_ihd_pkg::EV_UNDEFINED;
                        endcase
                    end
                end
            endcase
        end
    end

endmodule

[dv/cbor_item_head_decoder_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbor_item_head_decoder_test
// Self-checking testbench for the streaming CBOR item head decoder.
// A well-formed CBOR byte stream is fed in: a directed set of edge cases, then
// random items of every major type. The byte stream ends with one error,
// because an error latches until reset. A scoreboard decodes every accepted
// byte on its own and compares each event with the oldest expected one.
// Both stream sides idle at random.
// ----------------------------------------------------------------------------
module cbor_item_head_decoder_test;

    localparam int          LENGTH_BITS    = 32;
    localparam int          WIDEST_ARG     = 8;
    localparam int          RANDOM_BYTES   = 1750;
    localparam int          DRAIN_LIMIT    = 2000;
    localparam int          SETTLE_CYCLES  = 16;
    localparam logic [2:0]  MT_SPECIAL     = 3'd7;
    localparam logic [4:0]  AI_ARG1        = cbor_ihd_pkg::AI_IMM_MAX + 5'd1;
    localparam logic [4:0]  AI_ARG2        = cbor_ihd_pkg::AI_IMM_MAX + 5'd2;
    localparam logic [4:0]  AI_ARG4        = cbor_ihd_pkg::AI_IMM_MAX + 5'd3;
    localparam logic [4:0]  AI_BAD_FIRST   = cbor_ihd_pkg::AI_ARG8_MAX + 5'd1;
    localparam logic [63:0] INT32_MAX      = 64'h0000_0000_7FFF_FFFF;

    class cbor_event_scoreboard;
        cbor_ihd_pkg::phase_t      stage;
        logic [2:0]                cur_major;
        logic [3:0]                arg_left;
        logic [3:0]                arg_bytes;
        logic [63:0]               arg_value;
        logic [31:0]               string_left;
        cbor_ihd_pkg::head_event_t expected_events[$];
        int                        mismatches;
        int                        events_checked;
        int                        payload_events;
        logic [14:0]               kinds_seen;

        function new();
            stage          = cbor_ihd_pkg::PH_HEAD;
            cur_major      = '0;
            arg_left       = '0;
            arg_bytes      = '0;
            arg_value      = '0;
            string_left    = '0;
            mismatches     = 0;
            events_checked = 0;
            payload_events = 0;
            kinds_seen     = '0;
        endfunction

        function void push_event(cbor_ihd_pkg::event_kind_t kind, logic [63:0] arg,
                                 logic wide, logic [3:0] size, logic [7:0] pbyte,
                                 logic last, logic err);
            cbor_ihd_pkg::head_event_t ev;
            ev.kind     = kind;
            ev.argument = arg;
            ev.wide     = wide;
            ev.size     = size;
            ev.pbyte    = pbyte;
            ev.last     = last;
            ev.err      = err;
            expected_events.push_back(ev);
        endfunction

        function void complete_argument(logic [63:0] value, logic [3:0] size);
            stage = cbor_ihd_pkg::PH_HEAD;
            case (cur_major)
                cbor_ihd_pkg::MT_UINT, cbor_ihd_pkg::MT_NEGINT:
                    push_event(cur_major == cbor_ihd_pkg::MT_UINT ?
                               cbor_ihd_pkg::EV_UINT : cbor_ihd_pkg::EV_NEGINT, value,
                               value > INT32_MAX, size, '0, 1'b0, 1'b0);
                cbor_ihd_pkg::MT_BYTES, cbor_ihd_pkg::MT_TEXT,
                cbor_ihd_pkg::MT_ARRAY, cbor_ihd_pkg::MT_MAP:
                    if (size == WIDEST_ARG || (value >> LENGTH_BITS) != 0)
                    begin
                        stage = cbor_ihd_pkg::PH_ERROR;
                        push_event(cbor_ihd_pkg::EV_ERROR, value, 1'b0, size, '0, 1'b0,
                                   cbor_ihd_pkg::ERR_LONG_LENGTH);
                    end
                    else if (cur_major == cbor_ihd_pkg::MT_BYTES ||
                             cur_major == cbor_ihd_pkg::MT_TEXT)
                    begin
                        push_event(cur_major == cbor_ihd_pkg::MT_BYTES ?
                                   cbor_ihd_pkg::EV_BYTES : cbor_ihd_pkg::EV_TEXT, value,
                                   1'b0, size, '0, 1'b0, 1'b0);
                        string_left = value[31:0];
                        if (string_left != 0)
                            stage = cbor_ihd_pkg::PH_PAYLOAD;
                    end
                    else
                    begin
                        push_event(cur_major == cbor_ihd_pkg::MT_ARRAY ?
                                   cbor_ihd_pkg::EV_ARRAY : cbor_ihd_pkg::EV_MAP, value,
                                   1'b0, size, '0, 1'b0, 1'b0);
                    end
                cbor_ihd_pkg::MT_TAG:
                    push_event(cbor_ihd_pkg::EV_TAG, value, 1'b0, size, '0, 1'b0, 1'b0);
                default:
                    if (size != 0)
                        push_event(cbor_ihd_pkg::EV_EXTSPEC, value, 1'b0, size, '0,
                                   1'b0, 1'b0);
                    else if (value < cbor_ihd_pkg::AI_FALSE)
                        push_event(cbor_ihd_pkg::EV_SIMPLE, value, 1'b0, '0, '0,
                                   1'b0, 1'b0);
                    else
                        push_event(cbor_ihd_pkg::event_kind_t'(cbor_ihd_pkg::EV_FALSE +
                                   (value - cbor_ihd_pkg::AI_FALSE)), value,
                                   1'b0, '0, '0, 1'b0, 1'b0);
            endcase
        endfunction

        function void note_byte(logic [7:0] b);
            logic [4:0] info;
            info = b[4:0];
            case (stage)
                cbor_ihd_pkg::PH_HEAD:
                begin
                    cur_major = b[7:5];
                    if (info <= cbor_ihd_pkg::AI_IMM_MAX)
                        complete_argument({59'd0, info}, '0);
                    else if (info <= cbor_ihd_pkg::AI_ARG8_MAX)
                    begin
                        arg_bytes = 4'd1 << (info - AI_ARG1);
                        arg_left  = arg_bytes;
                        arg_value = '0;
                        stage     = cbor_ihd_pkg::PH_ARG;
                    end
                    else
                    begin
                        stage = cbor_ihd_pkg::PH_ERROR;
                        push_event(cbor_ihd_pkg::EV_ERROR, {59'd0, info}, 1'b0, '0, '0,
                                   1'b0, cbor_ihd_pkg::ERR_BAD_INFO);
                    end
                end
                cbor_ihd_pkg::PH_ARG:
                begin
                    arg_value = {arg_value[55:0], b};
                    if (arg_left != 0)
                        arg_left--;
                    if (arg_left == 0)
                        complete_argument(arg_value, arg_bytes);
                end
                cbor_ihd_pkg::PH_PAYLOAD:
                begin
                    if (string_left != 0)
                        string_left--;
                    push_event(cbor_ihd_pkg::EV_PAYLOAD, '0, 1'b0, '0, b,
                               string_left == 0, 1'b0);
                    if (string_left == 0)
                        stage = cbor_ihd_pkg::PH_HEAD;
                end
                default:
                    ;
            endcase
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_event(cbor_ihd_pkg::head_event_t got, logic [2:0] pad);
            cbor_ihd_pkg::head_event_t want;
            if (expected_events.size() == 0)
            begin
                $error("unexpected event: kind %0d argument 0x%0h", got.kind, got.argument);
                mismatches++;
                return;
            end
            want = expected_events.pop_front();
            events_checked++;
            if (want.kind == cbor_ihd_pkg::EV_PAYLOAD)
                payload_events++;
            kinds_seen[want.kind] = 1'b1;
            compare_field("event_kind", want.kind, got.kind);
            compare_field("argument", want.argument, got.argument);
            compare_field("wide_integer", want.wide, got.wide);
            compare_field("argument_size", want.size, got.size);
            compare_field("payload_byte", want.pbyte, got.pbyte);
            compare_field("last_payload", want.last, got.last);
            compare_field("error_code", want.err, got.err);
            compare_field("tdata padding", '0, pad);
        endfunction
    endclass

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic [4:0]  m_axis_tuser;
    logic        m_axis_tlast;

    cbor_event_scoreboard sb;
    bit sender_gaps   = 1'b1;
    bit receiver_gaps = 1'b1;
    int bytes_fed     = 0;
    string closing_error;

    cbor_item_head_decoder #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cbor_ihd_pkg::head_event_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.kind     = cbor_ihd_pkg::event_kind_t'(m_axis_tuser[3:0]);
            got.err      = m_axis_tuser[4];
            got.argument = m_axis_tdata[63:0];
            got.wide     = m_axis_tdata[64];
            got.size     = m_axis_tdata[68:65];
            got.pbyte    = m_axis_tdata[76:69];
            got.last     = m_axis_tlast;
            sb.check_event(got, m_axis_tdata[79:77]);
        end
        m_axis_tready <= !(receiver_gaps && $urandom_range(99) < 25);
    end

    task automatic send_byte(input logic [7:0] b);
        if (sender_gaps)
            while ($urandom_range(99) < 25)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_byte(b);
        bytes_fed++;
    endtask

    function automatic logic [4:0] width_info(int width);
        case (width)
            1:       return AI_ARG1;
            2:       return AI_ARG2;
            4:       return AI_ARG4;
            default: return cbor_ihd_pkg::AI_ARG8_MAX;
        endcase
    endfunction

    // Head, big-endian argument, then random payload for strings.
    task automatic send_item(input logic [2:0] major, input logic [63:0] value,
                             input int width);
        if (width == 0)
            send_byte({major, value[4:0]});
        else
        begin
            send_byte({major, width_info(width)});
            for (int i = width - 1; i >= 0; i--)
                send_byte(value[8*i +: 8]);
        end
        // an eight-byte string length is an error, so no payload follows it
        if ((major == cbor_ihd_pkg::MT_BYTES || major == cbor_ihd_pkg::MT_TEXT) &&
            width != WIDEST_ARG)
            for (int i = 0; i < int'(value[31:0]); i++)
                send_byte(8'($urandom));
    endtask

    function automatic int pick_width(bit allow_imm, bit allow_eight);
        int w;
        do
            w = 1 << $urandom_range(3);
        while (w == WIDEST_ARG && !allow_eight);
        if (allow_imm && $urandom_range(4) == 0)
            w = 0;
        return w;
    endfunction

    function automatic logic [63:0] random_argument(int width);
        logic [63:0] v;
        logic [63:0] mask;
        mask = (width >= WIDEST_ARG) ? '1 : (64'd1 << (8 * width)) - 64'd1;
        case ($urandom_range(7))
            0:       v = '0;
            1:       v = '1;
            2:       v = INT32_MAX + $urandom_range(1);
            default: v = {$urandom, $urandom};
        endcase
        return v & mask;
    endfunction

    task automatic send_random_item();
        logic [2:0]  major;
        logic [63:0] value;
        int          width;
        major = 3'($urandom_range(7));
        if (major == cbor_ihd_pkg::MT_BYTES || major == cbor_ihd_pkg::MT_TEXT)
        begin
            value = ($urandom_range(9) == 0) ? 64'($urandom_range(40))
                                             : 64'($urandom_range(10));
            width = pick_width(value <= cbor_ihd_pkg::AI_IMM_MAX, 1'b0);
        end
        else
        begin
            width = pick_width(1'b1, major != cbor_ihd_pkg::MT_ARRAY &&
                                     major != cbor_ihd_pkg::MT_MAP);
            value = (width == 0) ? 64'($urandom_range(cbor_ihd_pkg::AI_IMM_MAX))
                                 : random_argument(width);
        end
        send_item(major, value, width);
    endtask

    task automatic drain_and_hold();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.expected_events.size() != 0);
    endtask

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int waited;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(cbor_ihd_pkg::MT_UINT, 64'd0, 0);
        send_item(cbor_ihd_pkg::MT_UINT, 64'd23, 0);
        send_item(cbor_ihd_pkg::MT_UINT, 64'hFF, 1);
        send_item(cbor_ihd_pkg::MT_UINT, INT32_MAX, 4);
        send_item(cbor_ihd_pkg::MT_UINT, INT32_MAX + 64'd1, 4);
        send_item(cbor_ihd_pkg::MT_UINT, '1, 8);
        send_item(cbor_ihd_pkg::MT_NEGINT, 64'h1234, 2);
        send_item(cbor_ihd_pkg::MT_NEGINT, 64'd0, 8);
        send_item(cbor_ihd_pkg::MT_BYTES, 64'd0, 0);
        send_item(cbor_ihd_pkg::MT_TEXT, 64'd3, 0);
        send_item(cbor_ihd_pkg::MT_BYTES, 64'd1, 1);
        send_item(cbor_ihd_pkg::MT_TEXT, 64'd300, 2);
        send_item(cbor_ihd_pkg::MT_ARRAY, 64'd0, 0);
        send_item(cbor_ihd_pkg::MT_MAP, 64'hFFFF_FFFF, 4);
        send_item(cbor_ihd_pkg::MT_TAG, 64'd2, 0);
        send_item(cbor_ihd_pkg::MT_TAG, '1, 8);
        for (int v = 0; v <= cbor_ihd_pkg::AI_IMM_MAX;
             v += (v < cbor_ihd_pkg::AI_FALSE) ? 19 : 1)
            send_item(MT_SPECIAL, 64'(v), 0);
        send_item(MT_SPECIAL, 64'hFF, 1);
        send_item(MT_SPECIAL, 64'hABCD, 2);
        send_item(MT_SPECIAL, 64'h0123_4567_89AB_CDEF, 8);

        drain_and_hold();

        while (bytes_fed < RANDOM_BYTES)
        begin
            // quiet stretch with no idling on either side
            sender_gaps   = !(bytes_fed > 600 && bytes_fed < 950);
            receiver_gaps = sender_gaps;
            send_random_item();
            if (bytes_fed > 1200 && bytes_fed < 1210)
                drain_and_hold();
        end

        // An error latches until reset, so exactly one closes the stream.
        if ($urandom_range(1) == 0)
        begin
            closing_error = "invalid additional info";
            send_byte({3'($urandom_range(7)), AI_BAD_FIRST + 5'($urandom_range(3))});
        end
        else
        begin
            closing_error = "eight-byte length";
            send_item(3'($urandom_range(cbor_ihd_pkg::MT_MAP, cbor_ihd_pkg::MT_BYTES)),
                      random_argument(WIDEST_ARG), WIDEST_ARG);
        end
        repeat (4)
            send_byte(8'($urandom));
        s_axis_tvalid <= 1'b0;

        waited = 0;
        while (sb.expected_events.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (sb.expected_events.size() != 0)
        begin
            $error("%0d expected events never arrived", sb.expected_events.size());
            sb.mismatches++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Fed %0d bytes; checked %0d events (%0d payload bytes), %0d of 15 kinds.",
                 bytes_fed, sb.events_checked, sb.payload_events, $countones(sb.kinds_seen));
        $display("Stream closed by an %s error; trailing bytes were ignored.", closing_error);
        if (sb.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
